// ----- hdl/modem_link_frame_parser_defines.svh -----
// ----------------------------------------------------------------------------
// Modem link frame parser assertion macros
// Shared concurrent check forms, sampled on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef MODEM_LINK_FRAME_PARSER_DEFINES_SVH
`define MODEM_LINK_FRAME_PARSER_DEFINES_SVH

// Same-cycle implication.
`define MLFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MLFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/mlfp_pkg.sv -----
// ----------------------------------------------------------------------------
// mlfp_pkg
// Types, text constants and helpers for the modem link frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mlfp_pkg;

  typedef enum logic [1:0] {
    EV_NONE       = 2'd0,
    EV_CONNECT    = 2'd1,
    EV_DISCONNECT = 2'd2
  } mlfp_event_t;

  typedef struct packed {
    logic        link_up;
    mlfp_event_t link_event;
    logic        packet_done;
    logic        have_packet;
    logic        want_packet;
  } mlfp_status_t;

  localparam logic [3:0] CONN_LEN  = 4'd7;
  localparam logic [3:0] DISC_LEN  = 4'd10;
  localparam logic [7:0] CONN_HEAD = 8'h43;  // 'C'
  localparam logic [7:0] DISC_HEAD = 8'h4E;  // 'N'

  // "CONNECT"
  function automatic logic [7:0] conn_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h43;
      4'd1:    c = 8'h4F;
      4'd2:    c = 8'h4E;
      4'd3:    c = 8'h4E;
      4'd4:    c = 8'h45;
      4'd5:    c = 8'h43;
      4'd6:    c = 8'h54;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "NO CARRIER"
  function automatic logic [7:0] disc_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h4E;
      4'd1:    c = 8'h4F;
      4'd2:    c = 8'h20;
      4'd3:    c = 8'h43;
      4'd4:    c = 8'h41;
      4'd5:    c = 8'h52;
      4'd6:    c = 8'h52;
      4'd7:    c = 8'h49;
      4'd8:    c = 8'h45;
      4'd9:    c = 8'h52;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- hdl/mlfp_byte_if.sv -----
// ----------------------------------------------------------------------------
// mlfp_byte_if
// Valid/ready channel carrying one received modem byte per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mlfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/mlfp_status_if.sv -----
// ----------------------------------------------------------------------------
// mlfp_status_if
// Valid/ready channel carrying one link status item per received byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mlfp_status_if;
  logic        valid;
  logic        ready;
  logic        link_up;
  logic [1:0]  link_event;
  logic        packet_done;
  logic        have_packet;
  logic        want_packet;
  logic [31:0] forward_power;
  logic [31:0] rotation_power;

  modport source (
    output valid, output link_up, output link_event, output packet_done,
    output have_packet, output want_packet, output forward_power,
    output rotation_power, input ready
  );
  modport sink (
    input valid, input link_up, input link_event, input packet_done,
    input have_packet, input want_packet, input forward_power,
    input rotation_power, output ready
  );
endinterface

// ----- hdl/mlfp_widen.sv -----
// ----------------------------------------------------------------------------
// mlfp_widen
// Half to single precision bit widening; only +0 is special-cased, no subnormal, Inf or NaN handling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mlfp_widen (
  input  logic [15:0] half,
  output logic [31:0] single
);
  logic [7:0] expo;

  // rebias 15 -> 127
  assign expo = {3'b000, half[14:10]} + 8'd112;

  always_comb begin
    if (half == 16'h0000) begin
      single = 32'h0000_0000;
    end else begin
      single = {half[15], expo, half[9:0], 13'h0000};
    end
  end
endmodule

// ----- hdl/mlfp_core.sv -----
// ----------------------------------------------------------------------------
// mlfp_core
// Link state, text matching, packet assembly and latching for one byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modem_link_frame_parser_defines.svh"

module mlfp_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            rx_byte,
  output mlfp_pkg::mlfp_status_t status_next,
  output logic [31:0]           packet_next
);
  import mlfp_pkg::*;

  logic        link_connected;
  logic [3:0]  match_index;
  logic [7:0]  assembly_buffer [4];
  logic [1:0]  byte_position;
  logic [31:0] last_packet;
  logic        packet_seen;
  logic        reply_wanted;

  logic        link_connected_next;
  logic [3:0]  match_index_next;
  logic [1:0]  byte_position_next;
  logic [31:0] last_packet_next;
  logic        packet_seen_next;
  logic        reply_wanted_next;

  logic [3:0]  text_len;
  logic [7:0]  text_char;
  logic [7:0]  text_head;
  logic [3:0]  index_inc;
  logic        hit;
  logic        done;
  mlfp_event_t ev;

  assign text_len  = link_connected ? DISC_LEN : CONN_LEN;
  assign text_char = link_connected ? disc_char(match_index) : conn_char(match_index);
  assign text_head = link_connected ? DISC_HEAD : CONN_HEAD;
  assign index_inc = match_index + 4'd1;

  always_comb begin
    hit = 1'b0;
    if ((match_index < text_len) && (text_char == rx_byte)) begin
      if (index_inc >= text_len) begin
        hit              = 1'b1;
        match_index_next = 4'd0;
      end else begin
        match_index_next = index_inc;
      end
    end else if (rx_byte == text_head) begin
      match_index_next = 4'd1;
    end else begin
      match_index_next = 4'd0;
    end
  end

  always_comb begin
    link_connected_next = link_connected;
    byte_position_next  = byte_position;
    last_packet_next    = last_packet;
    packet_seen_next    = packet_seen;
    reply_wanted_next   = reply_wanted;
    done                = 1'b0;
    ev                  = EV_NONE;
    if (!link_connected) begin
      if (hit) begin
        link_connected_next = 1'b1;
        packet_seen_next    = 1'b0;
        reply_wanted_next   = 1'b0;
        ev                  = EV_CONNECT;
      end
    end else begin
      if (hit) begin
        link_connected_next = 1'b0;
        last_packet_next    = 32'h0000_0000;
        ev                  = EV_DISCONNECT;
      end
      byte_position_next = byte_position + 2'd1;
      // last byte of the packet goes straight into the latch
      if (byte_position == 2'd3) begin
        done              = 1'b1;
        packet_seen_next  = 1'b1;
        reply_wanted_next = 1'b1;
        last_packet_next  = {rx_byte, assembly_buffer[2], assembly_buffer[1],
                             assembly_buffer[0]};
      end
    end
  end

  assign status_next = '{
    link_up:     link_connected_next,
    link_event:  ev,
    packet_done: done,
    have_packet: packet_seen_next,
    want_packet: reply_wanted_next
  };
  assign packet_next = last_packet_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      link_connected <= 1'b0;
      match_index    <= 4'd0;
      byte_position  <= 2'd0;
      last_packet    <= 32'h0000_0000;
      packet_seen    <= 1'b0;
      reply_wanted   <= 1'b0;
    end else if (step) begin
      link_connected <= link_connected_next;
      match_index    <= match_index_next;
      byte_position  <= byte_position_next;
      last_packet    <= last_packet_next;
      packet_seen    <= packet_seen_next;
      reply_wanted   <= reply_wanted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step && link_connected) begin
      assembly_buffer[byte_position] <= rx_byte;
    end
  end

  `MLFP_ASSERT_NEXT(a_connect_clears, step && (ev == EV_CONNECT), link_connected && !packet_seen && !reply_wanted, "connect did not clear packet flags")
  `MLFP_ASSERT_NEXT(a_disc_zeroes, step && (ev == EV_DISCONNECT) && !done, !link_connected && (last_packet == 32'h0000_0000), "disconnect did not zero packet")
  `MLFP_ASSERT_NOW(a_flags_paired, 1'b1, packet_seen == reply_wanted, "packet flags diverged")
endmodule

// ----- hdl/modem_link_frame_parser.sv -----
// ----------------------------------------------------------------------------
// modem_link_frame_parser
// Modem byte stream parser: link connect/disconnect and 4-byte packets.
// ----------------------------------------------------------------------------
// One item in per byte received from the modem, one status item out per byte.
// Takes a new byte every cycle when the output side keeps up; each item
// passes an input register, then one combinational pass (text match, packet
// assembly, half-to-single widening) into the result register, which loads
// only when empty or being drained. While down the block looks for
// "CONNECT"; while up it buffers bytes into four-byte packets and looks for
// "NO CARRIER". Power words read 0 whenever the link is down.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modem_link_frame_parser_defines.svh"

module modem_link_frame_parser (
  input  logic          clk,
  input  logic          rst,
  mlfp_byte_if.sink     rx,
  mlfp_status_if.source status
);
  import mlfp_pkg::*;

  // input register
  logic       s1_valid;
  logic [7:0] s1_byte;

  // result register may load when empty or being drained
  logic advance;
  logic step;

  mlfp_status_t status_next;
  logic [31:0]  packet_next;
  logic [31:0]  fwd_single;
  logic [31:0]  rot_single;

  assign advance  = !status.valid || status.ready;
  assign rx.ready = !s1_valid || advance;
  assign step     = s1_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  mlfp_core u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .rx_byte     (s1_byte),
    .status_next (status_next),
    .packet_next (packet_next)
  );

  // bytes 0/1 -> forward, bytes 2/3 -> rotation, little-endian halves
  mlfp_widen u_widen_fwd (
    .half   (packet_next[15:0]),
    .single (fwd_single)
  );

  mlfp_widen u_widen_rot (
    .half   (packet_next[31:16]),
    .single (rot_single)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      status.valid <= 1'b0;
    end else if (advance) begin
      status.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status.link_up     <= status_next.link_up;
      status.link_event  <= status_next.link_event;
      status.packet_done <= status_next.packet_done;
      status.have_packet <= status_next.have_packet;
      status.want_packet <= status_next.want_packet;
      // powers forced to zero while the link is down
      status.forward_power  <= status_next.link_up ? fwd_single : 32'h0000_0000;
      status.rotation_power <= status_next.link_up ? rot_single : 32'h0000_0000;
    end
  end

  `MLFP_ASSERT_NOW(a_down_no_power, status.valid && !status.link_up, (status.forward_power == 32'h0000_0000) && (status.rotation_power == 32'h0000_0000), "power shown while link down")
  `MLFP_ASSERT_NOW(a_done_flags, status.valid && status.packet_done, status.have_packet && status.want_packet, "packet done without flags")
  `MLFP_ASSERT_NOW(a_connect_fresh, status.valid && (status.link_event == EV_CONNECT), status.link_up && !status.have_packet && !status.packet_done, "connect item inconsistent")
endmodule
